>>> hdl/rrts_pkg.sv
// Shared types and request codes for the round-robin task scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

  // Request kinds carried on the input tuser lane
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_DELAY = 2'd1,
    REQ_PICK  = 2'd2
  } req_e;

  // Per-cell command, decoded once per request by the sequencer
  typedef struct packed {
    logic tick_en;    // counter advances this cycle
    logic block_en;   // block this task and load its wake tick
    logic above_cur;  // task index is above the current task
  } cell_cmd_t;

  // Search tokens handed from one cell to the next
  typedef struct packed {
    logic pass_a;     // still searching among tasks above the current one
    logic pass_b;     // still searching from the lowest task up
  } search_t;

  // Grants raised by a cell that took one of the search tokens
  typedef struct packed {
    logic a;
    logic b;
  } grant_t;

endpackage

>>> hdl/rrts_cell.sv
// One task slot of the scheduler: blocked flag, wake tick and search link.
`timescale 1ns / 1ps

module rrts_cell
  import rrts_pkg::*;
#(
  parameter int TICK_WIDTH = 32,
  parameter bit IS_IDLE    = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_cmd_t             cmd_i,
  input  logic [TICK_WIDTH-1:0] new_tick_i,
  input  logic [TICK_WIDTH-1:0] wake_tick_i,
  input  search_t               search_i,
  output search_t               search_o,
  output grant_t                grant_o
);

  logic                  blocked_q, blocked_d;
  logic [TICK_WIDTH-1:0] wake_q;
  logic                  eligible;

  always_comb begin
    blocked_d = blocked_q;
    if (cmd_i.tick_en && blocked_q && (wake_q == new_tick_i)) begin
      blocked_d = 1'b0;
    end
    if (cmd_i.block_en) begin
      blocked_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= 1'b0;
    end else begin
      blocked_q <= blocked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.block_en) begin
      wake_q <= wake_tick_i;
    end
  end

  // Take a token if ready; pass it on otherwise
  assign eligible        = !IS_IDLE && !blocked_q;
  assign grant_o.a       = search_i.pass_a && eligible && cmd_i.above_cur;
  assign grant_o.b       = search_i.pass_b && eligible;
  assign search_o.pass_a = search_i.pass_a && !grant_o.a;
  assign search_o.pass_b = search_i.pass_b && !grant_o.b;

endmodule

>>> hdl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: sequencer, tick counter, cell row.
`timescale 1ns / 1ps

// Each request (tick, delay or pick) is captured from the input stream in the
// idle state; in the execute state that follows, the row of task cells updates
// and the result is loaded into the output register. The update carries the wake
// compare of every cell against the advanced counter, the counter + delay add,
// and the round-robin search, which ripples through the cell row as two tokens:
// the first looks only at tasks above the current one, the second restarts at
// task 1 and covers the wrap, so the current task is found last. Task 0 is idle
// and never takes a token; if no task is ready, idle is chosen. The output
// register holds a result until the sink takes it; while it is full and not
// being taken, the pending request waits and no new request is accepted.
// Counter and wake ticks wrap at TICK_WIDTH bits; tick_now shows the low 32
// bits, running_task the low 3 bits of the task index.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS  = 5,
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] delay_ticks
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [2:0] running_task, [3] switch_request,
                                     // [35:4] tick_now, [39:36] zero
);

  localparam int TaskW = $clog2(NUM_TASKS);
  localparam int WideW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;
  localparam int IdxW  = (TaskW > 3) ? TaskW : 3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [1:0]            req_q;
  logic [31:0]           delay_q;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [TaskW-1:0]      cur_q, cur_d;
  logic                  out_valid_q;
  logic [39:0]           out_data_q, out_data_d;

  logic                  s_fire;
  logic                  exec_fire;
  logic                  do_tick, do_delay, do_pick;
  logic                  sw_req;
  logic [WideW-1:0]      delay_wide;
  logic [TICK_WIDTH-1:0] new_tick;
  logic [TICK_WIDTH-1:0] wake_tick;
  logic [WideW-1:0]      tick_wide;
  logic [IdxW-1:0]       cur_wide;

  cell_cmd_t             cmd   [NUM_TASKS];
  search_t               chain [NUM_TASKS+1];
  grant_t                grant [NUM_TASKS];
  logic [NUM_TASKS-1:0]  grant_a_vec, grant_b_vec;
  logic [TaskW-1:0]      pick_a, pick_b, picked;

  // Handshake: one request in flight, captured in idle state
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  always_comb begin
    do_tick  = 1'b0;
    do_delay = 1'b0;
    do_pick  = 1'b0;
    case (req_q)
      REQ_TICK:  do_tick  = exec_fire;
      REQ_DELAY: do_delay = exec_fire && (cur_q != '0);
      REQ_PICK:  do_pick  = exec_fire;
      default:   ;  // unused code: no change, no switch
    endcase
  end

  // Reduce or extend the delay to the counter width
  assign delay_wide = WideW'(delay_q);
  assign new_tick   = tick_q + TICK_WIDTH'(1);
  assign wake_tick  = tick_q + delay_wide[TICK_WIDTH-1:0];

  // Decode per-cell commands and chain the cells
  assign chain[0] = '{pass_a: 1'b1, pass_b: 1'b1};

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    assign cmd[i].tick_en   = do_tick;
    assign cmd[i].block_en  = do_delay && (cur_q == TaskW'(i));
    assign cmd[i].above_cur = (TaskW'(i) > cur_q);

    rrts_cell #(
      .TICK_WIDTH (TICK_WIDTH),
      .IS_IDLE    (i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd[i]),
      .new_tick_i  (new_tick),
      .wake_tick_i (wake_tick),
      .search_i    (chain[i]),
      .search_o    (chain[i+1]),
      .grant_o     (grant[i])
    );

    assign grant_a_vec[i] = grant[i].a;
    assign grant_b_vec[i] = grant[i].b;
  end

  // Encode the one-hot grants; prefer the upper pass, then the wrap pass
  always_comb begin
    pick_a = '0;
    pick_b = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (grant_a_vec[i]) begin
        pick_a = pick_a | TaskW'(i);
      end
      if (grant_b_vec[i]) begin
        pick_b = pick_b | TaskW'(i);
      end
    end
    if (grant_a_vec != '0) begin
      picked = pick_a;
    end else begin
      picked = pick_b;
    end
  end

  // Next state of the scheduler and result word
  assign tick_d   = do_tick ? new_tick : tick_q;
  assign cur_d    = do_pick ? picked : cur_q;
  assign sw_req   = do_tick || do_delay;
  assign tick_wide = WideW'(tick_d);
  assign cur_wide  = IdxW'(cur_d);
  assign out_data_d = {4'b0000, tick_wide[31:0], sw_req, cur_wide[2:0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      cur_q   <= cur_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the captured request and the result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_q   <= s_axis_tuser;
      delay_q <= s_axis_tdata;
    end
    if (exec_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cur_q} < (TaskW+1)'(NUM_TASKS))
    else $error("current task index out of range");

  a_one_grant_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(grant_a_vec) && $onehot0(grant_b_vec))
    else $error("more than one cell took a search token");

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("request accepted while another is pending");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> m_axis_tvalid)
    else $error("result not presented after update");

  a_pick_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && (req_q == REQ_PICK)) |=> !m_axis_tdata[3])
    else $error("pick raised a switch request");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the round-robin task scheduler.
`timescale 1ns / 1ps

module tb;
  import rrts_pkg::*;

  localparam int          NUM_TASKS  = 5;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;   // spare request code, must change nothing
  localparam int          IDLE_PCT   = 26;
  localparam int          STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int          STEADY_LO  = 1200;   // window of cycles with no idling at all
  localparam int          STEADY_HI  = 2200;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] ticks;
  } sched_req_t;

  typedef struct {
    logic [2:0]  task_idx;
    logic        switch_req;
    logic [31:0] tick_now;
  } sched_outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // scheduler state as predicted by the testbench
  logic [31:0] tick_cnt;
  int          cur_task;
  logic        sleeping [NUM_TASKS];
  logic [31:0] wake_at  [NUM_TASKS];

  sched_req_t     pending_reqs [$];
  sched_outcome_t outcome_q    [$];

  int cycle_cnt   = 0;
  int stall_cnt   = 0;
  int fail_cnt    = 0;
  int n_checked   = 0;
  int n_ticks     = 0;
  int n_blocks    = 0;
  int n_wakes     = 0;
  int n_idle_pick = 0;
  int n_ignored   = 0;

  round_robin_task_scheduler #(
    .NUM_TASKS  (NUM_TASKS),
    .TICK_WIDTH (32)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit steady_now();
    return cycle_cnt >= STEADY_LO && cycle_cnt < STEADY_HI;
  endfunction

  function automatic bit idle_roll();
    return !steady_now() && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Apply one accepted request to the predicted state and queue its outcome.
  task automatic advance_scheduler(input logic [1:0] kind, input logic [31:0] amount);
    sched_outcome_t res;
    bit             found;
    int             cand;
    res.switch_req = 1'b0;
    found = 1'b0;
    case (kind)
      REQ_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
        for (int t = 0; t < NUM_TASKS; t++) begin
          if (sleeping[t] && wake_at[t] == tick_cnt) begin
            sleeping[t] = 1'b0;
            n_wakes++;
          end
        end
        res.switch_req = 1'b1;
        n_ticks++;
      end
      REQ_DELAY: begin
        if (cur_task != 0) begin
          wake_at[cur_task]  = tick_cnt + amount;
          sleeping[cur_task] = 1'b1;
          res.switch_req     = 1'b1;
          n_blocks++;
        end else begin
          n_ignored++;
        end
      end
      REQ_PICK: begin
        // tasks above the current one first, wrap round, current task last
        for (int step = 1; step <= NUM_TASKS; step++) begin
          cand = (cur_task + step) % NUM_TASKS;
          if (!found && cand != 0 && !sleeping[cand]) begin
            cur_task = cand;
            found    = 1'b1;
          end
        end
        if (!found) begin
          cur_task = 0;
          n_idle_pick++;
        end
      end
      default: n_ignored++;
    endcase
    res.task_idx = cur_task[2:0];
    res.tick_now = tick_cnt;
    outcome_q.push_back(res);
  endtask

  // Request driver: advance to the next pending request once the current one is taken.
  always @(posedge clk_i) begin
    sched_req_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        advance_scheduler(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && !idle_roll()) begin
          nxt = pending_reqs.pop_front();
          s_axis_tuser  <= nxt.kind;
          s_axis_tdata  <= nxt.ticks;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random back-pressure, compare every taken result with the oldest outcome.
  always @(posedge clk_i) begin
    sched_outcome_t exp_res;
    cycle_cnt++;
    m_axis_tready <= !idle_roll();
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result: tdata=%h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_res = outcome_q.pop_front();
        n_checked++;
        if (m_axis_tdata[2:0] !== exp_res.task_idx) begin
          $error("running_task: expected %0d, actual %0d", exp_res.task_idx,
                 m_axis_tdata[2:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[3] !== exp_res.switch_req) begin
          $error("switch_request: expected %0d, actual %0d", exp_res.switch_req,
                 m_axis_tdata[3]);
          fail_cnt++;
        end
        if (m_axis_tdata[35:4] !== exp_res.tick_now) begin
          $error("tick_now: expected %0d, actual %0d", exp_res.tick_now,
                 m_axis_tdata[35:4]);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", stall_cnt);
        $display("round_robin_task_scheduler test failed");
        $finish;
      end
    end
  end

  task automatic add_req(input logic [1:0] kind, input logic [31:0] ticks);
    sched_req_t r;
    r.kind  = kind;
    r.ticks = ticks;
    pending_reqs.push_back(r);
  endtask

  initial begin
    int roll;
    logic [31:0] amount;
    tick_cnt = '0;
    cur_task = 0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      sleeping[t] = 1'b0;
      wake_at[t]  = '0;
    end

    // Directed opening: spare code, delays while idle, wake-up and full rotation.
    add_req(REQ_UNUSED, 32'hA5A5_5A5A);
    add_req(REQ_TICK, 32'h0);
    add_req(REQ_DELAY, 32'hFFFF_FFFF);       // idle: ignored
    add_req(REQ_DELAY, 32'h0);               // idle: ignored
    add_req(REQ_PICK, 32'h0);                // idle -> task 1
    add_req(REQ_DELAY, 32'd2);               // task 1 sleeps until tick 3
    add_req(REQ_PICK, 32'h0);
    add_req(REQ_PICK, 32'h0);
    add_req(REQ_PICK, 32'h0);
    add_req(REQ_PICK, 32'h0);                // wraps past idle and the sleeping task
    add_req(REQ_TICK, 32'h0);
    add_req(REQ_TICK, 32'h0);                // task 1 wakes
    for (int t = 1; t < NUM_TASKS; t++) begin
      add_req(REQ_PICK, 32'h0);
      add_req(REQ_DELAY, 32'd3);             // put every task to sleep
    end
    add_req(REQ_PICK, 32'h0);                // nothing ready: idle
    add_req(REQ_TICK, 32'h0);
    add_req(REQ_TICK, 32'h0);
    add_req(REQ_TICK, 32'h0);
    add_req(REQ_PICK, 32'h0);
    add_req(REQ_UNUSED, 32'hFFFF_FFFF);

    // Random body: short sleeps so tasks keep cycling between ready and blocked.
    for (int i = 0; i < 1300; i++) begin
      roll = $urandom_range(99);
      if (roll < 38) begin
        add_req(REQ_TICK, $urandom());
      end else if (roll < 60) begin
        amount = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        add_req(REQ_DELAY, amount);
      end else if (roll < 95) begin
        add_req(REQ_PICK, $urandom());
      end else begin
        add_req(REQ_UNUSED, $urandom());
      end
    end

    // Tail: sleeps that never end within the run (zero and full-range amounts).
    add_req(REQ_PICK, 32'h0);
    add_req(REQ_DELAY, 32'h0);
    add_req(REQ_PICK, 32'h0);
    add_req(REQ_DELAY, 32'hFFFF_FFFF);
    for (int i = 0; i < 120; i++) begin
      roll = $urandom_range(99);
      if (roll < 30)
        add_req(REQ_TICK, $urandom());
      else if (roll < 60)
        add_req(REQ_DELAY, $urandom());
      else
        add_req(REQ_PICK, $urandom());
    end

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("checked %0d results: %0d ticks, %0d blocks, %0d wake-ups,", n_checked,
             n_ticks, n_blocks, n_wakes);
    $display("%0d picks that fell back to idle, %0d requests with no effect",
             n_idle_pick, n_ignored);
    if (fail_cnt == 0) begin
      $display("round_robin_task_scheduler test passed");
    end else begin
      $display("round_robin_task_scheduler test failed");
    end
    $finish;
  end

endmodule
